### hw/rtl/utf8_display_code_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 display code mapper - assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_DISPLAY_CODE_MAPPER_CORE_ASSERT_SVH
`define UTF8_DISPLAY_CODE_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define U8DM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dm check failed");
`define U8DM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dm check failed");
`else
`define U8DM_ASSERT_SAME(lbl, ante, cons)
`define U8DM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/u8dm_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 display code mapper - package
// Shared widths, byte class constants and the stage transfer type.
// ----------------------------------------------------------------------------
package u8dm_pkg;

  localparam int CP_W        = 21;
  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 9;
  localparam int ENTRY_W     = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 30;
  localparam int REPLACE_W   = 30;
  localparam int KEY_W       = 22;

  localparam int REPL_VALID_BIT = 29;
  localparam int KEY_VALID_BIT  = 21;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

  localparam logic [CODE_W-1:0] CUSTOM_BASE = 9'd256;

  typedef struct packed {
    logic            have_cp;
    logic [CP_W-1:0] cp;
    logic            fin;
  } u8dm_cp_t;

endpackage

### hw/rtl/u8dm_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 display code mapper - byte decoder
// Gathers lead and continuation bytes into codepoints; registered stage.
// ----------------------------------------------------------------------------
module u8dm_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          adv,
  input  logic [u8dm_pkg::BYTE_W-1:0]   text_byte,
  input  logic                          final_byte,
  output logic                          s1_valid,
  output u8dm_pkg::u8dm_cp_t            s1
);

  logic [u8dm_pkg::CP_W-1:0] partial;
  logic [u8dm_pkg::CP_W-1:0] partial_next;
  logic [1:0]                expected;
  logic [1:0]                expected_next;
  logic [u8dm_pkg::CP_W-1:0] cont;
  u8dm_pkg::u8dm_cp_t        dec;

  assign cont = {partial[u8dm_pkg::CP_W-7:0], text_byte[5:0]};

  always_comb begin
    partial_next  = partial;
    expected_next = expected;
    dec.have_cp   = 1'b0;
    dec.cp        = '0;
    dec.fin       = final_byte;
    if (expected != 2'd0) begin
      partial_next  = cont;
      expected_next = expected - 2'd1;
      if (expected == 2'd1) begin
        dec.cp      = cont;
        dec.have_cp = 1'b1;
      end
    end else if (!text_byte[7]) begin
      dec.cp      = {{(u8dm_pkg::CP_W-u8dm_pkg::BYTE_W){1'b0}}, text_byte};
      dec.have_cp = 1'b1;
    end else if ((text_byte & u8dm_pkg::LEAD2_MASK) == u8dm_pkg::LEAD2_VAL) begin
      partial_next  = {{(u8dm_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
      expected_next = 2'd1;
    end else if ((text_byte & u8dm_pkg::LEAD3_MASK) == u8dm_pkg::LEAD3_VAL) begin
      partial_next  = {{(u8dm_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
      expected_next = 2'd2;
    end else if ((text_byte & u8dm_pkg::LEAD4_MASK) == u8dm_pkg::LEAD4_VAL) begin
      partial_next  = {{(u8dm_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
      expected_next = 2'd3;
    end
    if (dec.have_cp) begin
      partial_next = '0;
    end
    if (final_byte) begin
      partial_next  = '0;
      expected_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= '0;
      expected <= 2'd0;
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        partial  <= partial_next;
        expected <= expected_next;
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= dec;
    end
  end

endmodule

### hw/rtl/u8dm_map.sv
// ----------------------------------------------------------------------------
// UTF-8 display code mapper - codepoint mapper
// Replacement and custom key lookup, slot tracking and result register.
// ----------------------------------------------------------------------------
module u8dm_map #(
  parameter int REPLACE_ENTRIES = 4,
  parameter int CUSTOM_KEYS     = 4,
  parameter int GLYPH_SLOTS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [u8dm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [u8dm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              adv,
  input  u8dm_pkg::u8dm_cp_t                s1,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              code_valid,
  output logic [u8dm_pkg::CODE_W-1:0]       display_code,
  output logic                              glyph_load,
  output logic [u8dm_pkg::ENTRY_W-1:0]      glyph_entry,
  output logic                              text_done
);

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int CNT_W  = $clog2(GLYPH_SLOTS + 1);
  localparam int KIDX_W = (CUSTOM_KEYS > 1) ? $clog2(CUSTOM_KEYS) : 1;
  localparam int CP_W   = u8dm_pkg::CP_W;

  logic [u8dm_pkg::REPLACE_W-1:0] replace_entry [REPLACE_ENTRIES];
  logic [u8dm_pkg::KEY_W-1:0]     custom_key    [CUSTOM_KEYS];
  logic [CUSTOM_KEYS-1:0]         slot_valid;
  logic [SLOT_W-1:0]              slot_num      [CUSTOM_KEYS];
  logic [CNT_W-1:0]               next_free;

  logic                           repl_hit;
  logic [7:0]                     repl_byte;
  logic                           key_hit;
  logic [KIDX_W-1:0]              key_idx;
  logic                           avail;
  logic                           cv;
  logic                           load;
  logic [u8dm_pkg::CODE_W-1:0]    code;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REPLACE_ENTRIES; k++) begin
        replace_entry[k] <= '0;
      end
      for (int k = 0; k < CUSTOM_KEYS; k++) begin
        custom_key[k] <= '0;
      end
    end else if (cfg_write) begin
      for (int k = 0; k < REPLACE_ENTRIES; k++) begin
        if (cfg_index == u8dm_pkg::CFG_INDEX_W'(k)) begin
          replace_entry[k] <= cfg_data[u8dm_pkg::REPLACE_W-1:0];
        end
      end
      for (int k = 0; k < CUSTOM_KEYS; k++) begin
        if (cfg_index == u8dm_pkg::CFG_INDEX_W'(REPLACE_ENTRIES + k)) begin
          custom_key[k] <= cfg_data[u8dm_pkg::KEY_W-1:0];
        end
      end
    end
  end

  // lowest index wins: scan downwards
  always_comb begin
    repl_hit  = 1'b0;
    repl_byte = '0;
    for (int k = REPLACE_ENTRIES - 1; k >= 0; k--) begin
      if (replace_entry[k][u8dm_pkg::REPL_VALID_BIT] &&
          replace_entry[k][u8dm_pkg::REPL_VALID_BIT-1:8] == s1.cp) begin
        repl_hit  = 1'b1;
        repl_byte = replace_entry[k][7:0];
      end
    end
    key_hit = 1'b0;
    key_idx = '0;
    for (int k = CUSTOM_KEYS - 1; k >= 0; k--) begin
      if (custom_key[k][u8dm_pkg::KEY_VALID_BIT] &&
          custom_key[k][CP_W-1:0] == s1.cp) begin
        key_hit = 1'b1;
        key_idx = KIDX_W'(k);
      end
    end
  end

  assign avail = (next_free < CNT_W'(GLYPH_SLOTS));

  always_comb begin
    cv   = 1'b0;
    load = 1'b0;
    code = '0;
    if (s1.have_cp) begin
      if (repl_hit) begin
        cv   = 1'b1;
        code = {1'b0, repl_byte};
      end else if (avail && key_hit) begin
        cv = 1'b1;
        if (slot_valid[key_idx]) begin
          code = u8dm_pkg::CUSTOM_BASE | u8dm_pkg::CODE_W'(slot_num[key_idx]);
        end else begin
          load = 1'b1;
          code = u8dm_pkg::CUSTOM_BASE | u8dm_pkg::CODE_W'(next_free[SLOT_W-1:0]);
        end
      end else if (s1.cp[CP_W-1:8] == '0) begin
        cv   = 1'b1;
        code = {1'b0, s1.cp[7:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_free  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= cv || s1.fin;
        if (s1.fin) begin
          slot_valid <= '0;
          next_free  <= '0;
        end else if (load) begin
          slot_valid[key_idx] <= 1'b1;
          next_free           <= next_free + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      slot_num[key_idx] <= next_free[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_valid   <= cv;
      display_code <= code;
      glyph_load   <= load;
      glyph_entry  <= load ? u8dm_pkg::ENTRY_W'(key_idx) : '0;
      text_done    <= s1.fin;
    end
  end

endmodule

### hw/rtl/utf8_display_code_mapper_core.sv
// ----------------------------------------------------------------------------
// UTF-8 display code mapper core
// Pipeline: the decode stage registers the codepoint, then the map stage registers the result.
// Throughput: one byte per cycle unless out_ready stalls; slot and decoder loops each close in one register.
// Reset (synchronous, active high) clears config, decoder state and slots.
// ----------------------------------------------------------------------------
`include "utf8_display_code_mapper_core_assert.svh"

module utf8_display_code_mapper_core #(
  parameter int REPLACE_ENTRIES = 4,
  parameter int CUSTOM_KEYS     = 4,
  parameter int GLYPH_SLOTS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [u8dm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [u8dm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [u8dm_pkg::BYTE_W-1:0]       text_byte,
  input  logic                              final_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              code_valid,
  output logic [u8dm_pkg::CODE_W-1:0]       display_code,
  output logic                              glyph_load,
  output logic [u8dm_pkg::ENTRY_W-1:0]      glyph_entry,
  output logic                              text_done
);

  logic               s1_valid;
  u8dm_pkg::u8dm_cp_t s1;
  logic               adv;
  logic               take;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;
  assign take     = in_valid && in_ready;

  u8dm_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .adv        (adv),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  u8dm_map #(
    .REPLACE_ENTRIES (REPLACE_ENTRIES),
    .CUSTOM_KEYS     (CUSTOM_KEYS),
    .GLYPH_SLOTS     (GLYPH_SLOTS)
  ) u_map (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .adv          (adv),
    .s1           (s1),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .code_valid   (code_valid),
    .display_code (display_code),
    .glyph_load   (glyph_load),
    .glyph_entry  (glyph_entry),
    .text_done    (text_done)
  );

  `U8DM_ASSERT_SAME(a_nocode_zero, out_valid && !code_valid, display_code == '0 && !glyph_load)
  `U8DM_ASSERT_SAME(a_nocode_end, out_valid && !code_valid, text_done)
  `U8DM_ASSERT_SAME(a_load_custom, out_valid && glyph_load, code_valid && display_code[8])
  `U8DM_ASSERT_NEXT(a_stage_drain, s1_valid && !in_ready, s1_valid)

endmodule
